/* sv/bfp_pkg.sv */
`timescale 1ns / 1ps
// shared types, opcodes and helper functions for the bit field pack buffer
// no dependencies
package bfp_pkg;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_REWIND = 2'd2;

  localparam logic [6:0] MAX_FIELD = 7'd64;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] value;
    logic [6:0]  bit_count;
  } in_item_t;

  typedef struct packed {
    logic [63:0] read_value;
    logic        end_reached;
    logic        overflow;
    logic [15:0] bits_stored;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic append_step;
    logic read_step;
    logic load_out;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic go_append;
    logic go_read;
    logic app_last;
    logic rd_last;
    logic out_busy;
  } dp_status_t;

  // mask of the low w bits, w in 0..8
  function automatic logic [7:0] low_mask(input logic [3:0] w);
    logic [8:0] m;
    m = (9'd1 << w) - 9'd1;
    return m[7:0];
  endfunction

  function automatic logic [7:0] rev8(input logic [7:0] b);
    logic [7:0] r;
    for (int j = 0; j < 8; j++) begin
      r[7-j] = b[j];
    end
    return r;
  endfunction

endpackage

/* sv/bfp_stream_if.sv */
`timescale 1ns / 1ps
// valid/ready channel carrying one payload of type T
// no dependencies
interface bfp_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/bit_field_pack_buffer_top.sv */
`timescale 1ns / 1ps
// top level of the bit field pack buffer: controller, datapath and byte store
// depends on bfp_pkg, bfp_stream_if, bfp_ctrl, bfp_datapath, bfp_ram
//
// Bit stream writer and reader over a store of STORE_BYTES bytes. An append
// (op 0) adds the low bit_count bits of value, most significant first, each
// stream bit going to the next position, low bit of each byte first; bits
// that do not fit are dropped and overflow is set. A read (op 1) gathers
// bit_count bits from the read pointer, most significant first; running out
// of written bits sets end_reached and returns the partial value shifted
// left once more. A rewind (op 2) moves the read pointer to zero. Counts
// above 64 act as 64. Every transaction gives one result. An append or read
// moves at most one byte of the store per cycle, so a field of n bits
// starting at bit offset o is handled byte by byte over the store bytes it
// touches, at most ceil((o+n)/8), with an extra step when an append finds
// the store full or a read runs out of written bits. The item is accepted in
// the idle state and its result is loaded in the finish state. A new item is
// taken only once the previous one has finished; a result may still wait in
// the output register while the next item runs, and that item holds in the
// finish state until the output register is free.
module bit_field_pack_buffer_top #(
  parameter int STORE_BYTES = 4096
) (
  input logic         clk,
  input logic         rst,
  bfp_stream_if.sink   cmd,
  bfp_stream_if.source rsp
);

  bfp_pkg::ctrl_cmd_t  ctl;
  bfp_pkg::dp_status_t status;
  bfp_pkg::out_item_t  out_data;
  logic                out_valid;

  bfp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .status    (status),
    .ctl       (ctl)
  );

  bfp_datapath #(
    .STORE_BYTES (STORE_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .item      (cmd.data),
    .ctl       (ctl),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (rsp.ready),
    .out_data  (out_data)
  );

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

endmodule

/* sv/bfp_ram.sv */
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read
// no dependencies
module bfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/bfp_ctrl.sv */
`timescale 1ns / 1ps
// sequencing state machine for the bit field pack buffer
// depends on bfp_pkg
module bfp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  bfp_pkg::dp_status_t status,
  output bfp_pkg::ctrl_cmd_t  ctl
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_APPEND = 2'd1;
  localparam logic [1:0] S_READ   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next      = state;
    ctl             = '0;
    cmd_ready       = 1'b0;
    case (state)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          ctl.start = 1'b1;
          if (status.go_append) begin
            state_next = S_APPEND;
          end else if (status.go_read) begin
            state_next = S_READ;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_APPEND: begin
        ctl.append_step = 1'b1;
        if (status.app_last) begin
          state_next = S_FINISH;
        end
      end
      S_READ: begin
        ctl.read_step = 1'b1;
        if (status.rd_last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!status.out_busy) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* sv/bfp_datapath.sv */
`timescale 1ns / 1ps
// pointers, field shifter, byte store and result register
// depends on bfp_pkg and bfp_ram
module bfp_datapath #(
  parameter int STORE_BYTES = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  bfp_pkg::in_item_t    item,
  input  bfp_pkg::ctrl_cmd_t   ctl,
  output bfp_pkg::dp_status_t  status,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bfp_pkg::out_item_t   out_data
);

  localparam int STORE_BITS = STORE_BYTES * 8;
  localparam int PW = $clog2(STORE_BITS + 1);
  localparam int AW = $clog2(STORE_BYTES);

  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [PW-1:0] rp_next;
  logic [63:0]   value_sh;
  logic [6:0]    n_rem;
  logic [63:0]   result;
  logic          eof;
  logic          ovf;
  logic [7:0]    tail;

  logic [6:0]    n_sat;
  logic [2:0]    wo;
  logic [2:0]    ro;
  logic [3:0]    w_room;
  logic [3:0]    r_room;
  logic [3:0]    k_app;
  logic [3:0]    k_rd0;
  logic [3:0]    k_rd;
  logic          full;
  logic [7:0]    cand;
  logic [7:0]    placed;
  logic [7:0]    fmask;
  logic [7:0]    wbyte;
  logic [PW-1:0] avail;
  logic          avail_zero;
  logic [7:0]    rdata;
  logic [7:0]    gbits;
  logic [63:0]   result_next;

  always_comb begin
    n_sat = (item.bit_count > bfp_pkg::MAX_FIELD) ? bfp_pkg::MAX_FIELD : item.bit_count;

    // append: bits of the field fill the current byte upward from the write offset
    wo     = wp[2:0];
    w_room = 4'd8 - {1'b0, wo};
    k_app  = (n_rem < {3'b0, w_room}) ? n_rem[3:0] : w_room;
    full   = (wp == PW'(STORE_BITS));
    for (int j = 0; j < 8; j++) begin
      cand[j] = value_sh[63-j];
    end
    placed = cand << wo;
    fmask  = bfp_pkg::low_mask({1'b0, wo} + k_app) & ~bfp_pkg::low_mask({1'b0, wo});
    wbyte  = (tail & bfp_pkg::low_mask({1'b0, wo})) | (placed & fmask);

    // read: take up to the end of the byte, the field or the written data
    ro         = rp[2:0];
    r_room     = 4'd8 - {1'b0, ro};
    k_rd0      = (n_rem < {3'b0, r_room}) ? n_rem[3:0] : r_room;
    avail      = wp - rp;
    avail_zero = (avail == '0);
    k_rd       = (avail < PW'(k_rd0)) ? avail[3:0] : k_rd0;
    gbits      = bfp_pkg::rev8(rdata >> ro) >> (4'd8 - k_rd);
    result_next = (result << k_rd) | {56'b0, gbits};

    rp_next = rp;
    if (ctl.start && item.op == bfp_pkg::OP_REWIND) begin
      rp_next = '0;
    end else if (ctl.read_step && !avail_zero) begin
      rp_next = rp + PW'(k_rd);
    end

    status.go_append = (item.op == bfp_pkg::OP_APPEND) && (n_sat != 7'd0);
    status.go_read   = (item.op == bfp_pkg::OP_READ) && (n_sat != 7'd0);
    status.app_last  = full || (n_rem == {3'b0, k_app});
    status.rd_last   = avail_zero || (n_rem == {3'b0, k_rd});
    status.out_busy  = out_valid && !out_ready;
  end

  bfp_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ctl.append_step && !full),
    .waddr (wp[AW+2:3]),
    .wdata (wbyte),
    .raddr (rp_next[AW+2:3]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      n_rem    <= n_sat;
      value_sh <= item.value << (7'd64 - n_sat);
      result   <= '0;
      eof      <= 1'b0;
      ovf      <= 1'b0;
    end else if (ctl.append_step) begin
      if (full) begin
        ovf <= 1'b1;
      end else begin
        n_rem    <= n_rem - {3'b0, k_app};
        value_sh <= value_sh << k_app;
        tail     <= wbyte;
      end
    end else if (ctl.read_step) begin
      if (avail_zero) begin
        result <= result << 1;
        eof    <= 1'b1;
      end else begin
        result <= result_next;
        n_rem  <= n_rem - {3'b0, k_rd};
      end
    end
    if (ctl.load_out) begin
      out_data.read_value  <= result;
      out_data.end_reached <= eof;
      out_data.overflow    <= ovf;
      out_data.bits_stored <= 16'(wp);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp        <= '0;
      rp        <= '0;
      out_valid <= 1'b0;
    end else begin
      rp <= rp_next;
      if (ctl.append_step && !full) begin
        wp <= wp + PW'(k_app);
      end
      if (ctl.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
